// ===== hdl/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg
// Types and constants shared by the 3x3 RGB box filter and its checker.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Nine 8-bit values sum to at most 2295, which fits in 12 bits.
    // floor(s / 9) == (s * 1821) >> 14 for every s in that range.
    localparam int              SUM_W      = 12;
    localparam int              DIV9_W     = 11;
    localparam logic [DIV9_W-1:0] DIV9_MUL = 11'd1821;
    localparam int              DIV9_SHIFT = 14;
    localparam int              PROD_W     = SUM_W + DIV9_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             run_last;
    } t_pix_out;

endpackage

// ===== hdl/box_filter_3x3_rgb_core.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_core
// A pixel passes the stage 1, stage 2 and output registers before the first
// word that it causes appears.
// Throughput: one pixel per cycle unless the output stalls; the single output
// port sets the rate when a pixel causes two or three words (row ends, last row).
// Reset: synchronous; pipeline and position clear at once, line stores are
// not cleared (no clearing pass), size registers return to 640 x 480.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb_core
    import bf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_pix_in               i_in_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_pix_out              o_out_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = (CW + 1 > CFG_W_BITS) ? CW + 1 : CFG_W_BITS;
    localparam int HEW = (RW + 1 > CFG_H_BITS) ? RW + 1 : CFG_H_BITS;
    localparam int MW  = 2 * PIX_W;

    typedef struct packed {
        logic r_ge2;
        logic c_nz;
        logic c_ge2;
        logic c_last;
        logic row_edge;
    } t_s1_flags;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             filt;
    } t_cand;

    // Configuration and position.
    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         n_col;
    logic [RW-1:0]         n_row;
    logic [WEW-1:0]        w_eff;
    logic [HEW-1:0]        h_eff;
    logic                  restart;
    logic [CW-1:0]         c_eff;
    logic [RW-1:0]         r_eff;
    logic                  col_wrap;
    logic                  row_wrap;
    logic                  accept;

    // Line store: each entry holds {two rows up, one row up} for one column.
    logic [MW-1:0]         mem [MAX_WIDTH];
    logic [MW-1:0]         r_rd_q;
    logic                  r_fwd;
    logic [MW-1:0]         r_fwd_q;
    logic [MW-1:0]         mem_q;
    logic [MW-1:0]         wr_data;

    // Stage 1: pixel waiting for its line-store data.
    logic                  r_s1_valid;
    logic [PIX_W-1:0]      r_s1_px;
    logic [RW-1:0]         r_s1_row;
    logic [CW-1:0]         r_s1_col;
    t_s1_flags             r_s1_flg;
    logic                  s1_adv;

    logic [PIX_W-1:0]      r_win [6];
    logic [PIX_W-1:0]      cur [3];
    logic [SUM_W-1:0]      sum [3];
    t_cand                 cand [3];
    logic [2:0]            cand_v;

    // Stage 2: up to three pending result words of one pixel.
    t_cand                 r_cand [3];
    logic [SUM_W-1:0]      r_sum [3];
    logic [2:0]            r_pend;
    logic [1:0]            sel;
    logic [2:0]            sel_mask;
    logic                  last;
    logic                  s2_free;

    // Output register.
    logic                  r_out_valid;
    t_pix_out              r_out;
    logic                  out_free;
    t_cand                 sel_cand;
    logic [PROD_W-1:0]     prod [3];
    logic [PIX_W-1:0]      out_pix;
    t_pix_out              out_word;

    // ------------------------------------------------------------------
    // Position and frame size
    // ------------------------------------------------------------------
    always_comb begin
        w_eff = WEW'(r_cfg_w);
        if (r_cfg_w == '0) begin
            w_eff = WEW'(1);
        end else if (WEW'(r_cfg_w) > WEW'(MAX_WIDTH)) begin
            w_eff = WEW'(MAX_WIDTH);
        end
        h_eff = HEW'(r_cfg_h);
        if (r_cfg_h == '0) begin
            h_eff = HEW'(1);
        end else if (HEW'(r_cfg_h) > HEW'(MAX_HEIGHT)) begin
            h_eff = HEW'(MAX_HEIGHT);
        end
    end

    // A size change can leave the position outside the frame; it then restarts.
    assign restart  = (WEW'(r_col) >= w_eff) || (HEW'(r_row) >= h_eff);
    assign c_eff    = restart ? '0 : r_col;
    assign r_eff    = restart ? '0 : r_row;
    assign col_wrap = (WEW'(c_eff) + WEW'(1)) >= w_eff;
    assign row_wrap = (HEW'(r_eff) + HEW'(1)) >= h_eff;
    assign n_col    = col_wrap ? '0 : c_eff + CW'(1);
    assign n_row    = col_wrap ? (row_wrap ? '0 : r_eff + RW'(1)) : r_eff;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && s2_free;
    assign o_ready  = !r_s1_valid || s2_free;

    // ------------------------------------------------------------------
    // Stage 1 datapath
    // ------------------------------------------------------------------
    assign mem_q   = r_fwd ? r_fwd_q : r_rd_q;
    assign cur[0]  = mem_q[MW-1:PIX_W];
    assign cur[1]  = mem_q[PIX_W-1:0];
    assign cur[2]  = r_s1_px;
    assign wr_data = {cur[1], r_s1_px};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                sum[k] = sum[k] + SUM_W'(r_win[i][k*CH_W +: CH_W])
                                + SUM_W'(r_win[3+i][k*CH_W +: CH_W])
                                + SUM_W'(cur[i][k*CH_W +: CH_W]);
            end
        end
    end

    // Candidate 0 is column c-1 of the center row: filtered, or the left
    // border pixel when c is 1. Candidate 1 is the right border pixel of the
    // center row, candidate 2 the pixel itself on the first or last row.
    always_comb begin
        cand[0].pix  = r_win[4];
        cand[0].row  = ROW_W'(r_s1_row - RW'(1));
        cand[0].col  = COL_W'(r_s1_col - CW'(1));
        cand[0].filt = r_s1_flg.c_ge2;
        cand[1].pix  = cur[1];
        cand[1].row  = ROW_W'(r_s1_row - RW'(1));
        cand[1].col  = COL_W'(r_s1_col);
        cand[1].filt = 1'b0;
        cand[2].pix  = r_s1_px;
        cand[2].row  = ROW_W'(r_s1_row);
        cand[2].col  = COL_W'(r_s1_col);
        cand[2].filt = 1'b0;
        cand_v[0]    = r_s1_flg.r_ge2 && r_s1_flg.c_nz;
        cand_v[1]    = r_s1_flg.r_ge2 && r_s1_flg.c_last;
        cand_v[2]    = r_s1_flg.row_edge;
    end

    // ------------------------------------------------------------------
    // Stage 2 word selection and output formatting
    // ------------------------------------------------------------------
    always_comb begin
        priority if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
    end

    assign sel_mask = 3'b001 << sel;
    assign last     = (r_pend & ~sel_mask) == '0;
    assign s2_free  = (r_pend == '0) || (out_free && last);
    assign sel_cand = r_cand[sel];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = PROD_W'(r_sum[k]) * PROD_W'(DIV9_MUL);
        end
        out_pix = sel_cand.filt ? {prod[2][DIV9_SHIFT +: CH_W],
                                   prod[1][DIV9_SHIFT +: CH_W],
                                   prod[0][DIV9_SHIFT +: CH_W]}
                                : sel_cand.pix;
        out_word.out_red   = out_pix[CH_W-1:0];
        out_word.out_green = out_pix[2*CH_W-1:CH_W];
        out_word.out_blue  = out_pix[3*CH_W-1:2*CH_W];
        out_word.out_row   = sel_cand.row;
        out_word.out_col   = sel_cand.col;
        out_word.run_last  = last;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= FRAME_WIDTH_RST;
            r_cfg_h     <= FRAME_HEIGHT_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_BITS-1:0];
                    CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_BITS-1:0];
                endcase
            end
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_pend <= cand_v;
                for (int i = 0; i < 3; i++) begin
                    r_win[i]   <= r_win[3+i];
                    r_win[3+i] <= cur[i];
                end
            end else if (out_free && (r_pend != '0)) begin
                r_pend <= r_pend & ~sel_mask;
            end
            if (out_free) begin
                r_out_valid <= (r_pend != '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px           <= {i_in_data.in_blue, i_in_data.in_green, i_in_data.in_red};
            r_s1_row          <= r_eff;
            r_s1_col          <= c_eff;
            r_s1_flg.r_ge2    <= r_eff >= RW'(2);
            r_s1_flg.c_nz     <= c_eff != '0;
            r_s1_flg.c_ge2    <= c_eff >= CW'(2);
            r_s1_flg.c_last   <= WEW'(c_eff) == (w_eff - WEW'(1));
            r_s1_flg.row_edge <= (r_eff == '0) || (HEW'(r_eff) == (h_eff - HEW'(1)));
        end
        if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_cand[i] <= cand[i];
                r_sum[i]  <= sum[i];
            end
        end
        if (out_free && (r_pend != '0)) begin
            r_out <= out_word;
        end
    end

    // ------------------------------------------------------------------
    // Line store. A write and a read of the same column at one edge happen
    // for one-pixel-wide frames and after a restart; the written word is then forwarded.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem[r_s1_col] <= wr_data;
        end
        if (accept) begin
            r_rd_q  <= mem[c_eff];
            r_fwd   <= s1_adv && (r_s1_col == c_eff);
            r_fwd_q <= wr_data;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

endmodule

// ===== hdl/bf3_checker.sv =====
// ----------------------------------------------------------------------------
// bf3_checker
// Port-level checks for the 3x3 RGB box filter, bound to the top level.
// ----------------------------------------------------------------------------
module bf3_checker
    import bf3_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_ready,
    input logic     o_valid,
    input logic     i_ready,
    input t_pix_out o_out_data
);

    // The pipeline is three registers deep, so no word can show up before an
    // accepted pixel has passed through all three.
    a_no_early_word: assert property (@(posedge i_clk)
        ($past(!i_rst_n) || $past(!i_rst_n, 2)) |-> !o_valid)
        else $error("output word too soon after reset");

    // With the pipeline empty, the input side must be open.
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_ready)
        else $error("input not ready after reset");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

endmodule

bind box_filter_3x3_rgb_core bf3_checker u_bf3_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_data (o_out_data)
);

// ===== sim/box_filter_3x3_rgb_core_tb.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_core_tb
// Self-checking bench for the 3x3 RGB box filter. Pixels are streamed in raster
// order under varying frame sizes. A behavioral predictor keeps its own line
// stores, window and position, and queues the words each pixel must produce.
// Every output word is compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb_core_tb
    import bf3_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W       = 2048;
    localparam int MAX_H       = 4096;
    localparam int LAT_PAD     = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    t_pix_in               i_in_data;
    logic                  o_valid;
    logic                  i_ready;
    t_pix_out              o_out_data;

    // Predictor state.
    logic [CFG_W_BITS-1:0] width_reg  = FRAME_WIDTH_RST;
    logic [CFG_H_BITS-1:0] height_reg = FRAME_HEIGHT_RST;
    t_pix_in               line_above [MAX_W];
    t_pix_in               line_above2 [MAX_W];
    t_pix_in               win [6];
    int                    col_pos = 0;
    int                    row_pos = 0;
    t_pix_out              expected_words [$];

    int  fail_count   = 0;
    int  pixels_sent  = 0;
    int  cycle_count  = 0;
    int  src_idle_pct = 0;
    int  stall_pct    = 0;
    logic hold_on;
    event hold_go;

    box_filter_3x3_rgb_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_pix_out make_word(input t_pix_in v, input int r, input int c);
        t_pix_out o;
        o.out_red   = v.in_red;
        o.out_green = v.in_green;
        o.out_blue  = v.in_blue;
        o.out_row   = ROW_W'(r);
        o.out_col   = COL_W'(c);
        o.run_last  = 1'b0;
        return o;
    endfunction

    // Queues the words caused by one accepted pixel and advances the position.
    function automatic void box_filter_step(input t_pix_in px);
        int       w_eff;
        int       h_eff;
        int       r;
        int       c;
        int       n;
        int       s_red;
        int       s_green;
        int       s_blue;
        t_pix_in  cur [3];
        t_pix_in  avg;
        t_pix_out words [3];
        w_eff = int'(width_reg);
        h_eff = int'(height_reg);
        if (w_eff == 0) w_eff = 1;
        if (w_eff > MAX_W) w_eff = MAX_W;
        if (h_eff == 0) h_eff = 1;
        if (h_eff > MAX_H) h_eff = MAX_H;
        if (col_pos >= w_eff || row_pos >= h_eff) begin
            col_pos = 0;
            row_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        n = 0;
        cur[0] = line_above2[c];
        cur[1] = line_above[c];
        cur[2] = px;

        // The center row r-1 finishes before the current pixel is passed on.
        if (r >= 2) begin
            if (c == 1) begin
                words[n] = make_word(win[4], r - 1, 0);
                n++;
            end
            if (c >= 2) begin
                s_red   = 0;
                s_green = 0;
                s_blue  = 0;
                for (int i = 0; i < 3; i++) begin
                    s_red   += win[i].in_red + win[3+i].in_red + cur[i].in_red;
                    s_green += win[i].in_green + win[3+i].in_green + cur[i].in_green;
                    s_blue  += win[i].in_blue + win[3+i].in_blue + cur[i].in_blue;
                end
                avg.in_red   = CH_W'(s_red / 9);
                avg.in_green = CH_W'(s_green / 9);
                avg.in_blue  = CH_W'(s_blue / 9);
                words[n] = make_word(avg, r - 1, c - 1);
                n++;
            end
            if (c == w_eff - 1) begin
                words[n] = make_word(cur[1], r - 1, c);
                n++;
            end
        end
        if (r == 0 || r == h_eff - 1) begin
            words[n] = make_word(px, r, c);
            n++;
        end
        if (n > 0) begin
            words[n-1].run_last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            expected_words.insert(expected_words.size(), words[k]);
        end

        for (int i = 0; i < 3; i++) begin
            win[i]   = win[3+i];
            win[3+i] = cur[i];
        end
        line_above2[c] = cur[1];
        line_above[c]  = px;

        if (c + 1 >= w_eff) begin
            col_pos = 0;
            row_pos = (r + 1 >= h_eff) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in p;
        case ($urandom_range(7))
            0: p = '0;
            1: p = '1;
            default: p = t_pix_in'(PIX_W'($urandom));
        endcase
        return p;
    endfunction

    // Offers one pixel and returns right after the edge that takes it. Valid is
    // left high so a back-to-back word needs no second assignment in one step.
    task automatic send_pixel(input t_pix_in px);
        if ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_valid   <= 1'b1;
        i_in_data <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        box_filter_step(px);
        pixels_sent++;
    endtask

    // Sends random pixels until the predicted position wraps to the frame start.
    task automatic send_frame();
        do send_pixel(random_pixel()); while (col_pos != 0 || row_pos != 0);
    endtask

    // Stops the sender, waits for every queued word, then lets the pipeline settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (LAT_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) begin
            width_reg = value[CFG_W_BITS-1:0];
        end else begin
            height_reg = value;
        end
        @(posedge i_clk);
    endtask

    // Default 640 x 480 frame: the first row is emitted as it arrives.
    task automatic test_reset_size();
        send_pixel('0);
        send_pixel('1);
    endtask

    // Zero sizes act as 1 x 1; the position left at column 2 must restart.
    task automatic test_zero_size();
        drain_results();
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '0);
        send_pixel(random_pixel());
        send_pixel(random_pixel());
    endtask

    // Both registers at their top values, which saturate to the maximum frame.
    task automatic test_max_size();
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'h0FFF);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        send_pixel('1);
        send_pixel(t_pix_in'(24'hA5_5A_C3));
        send_pixel('0);
    endtask

    // Smallest frame with an interior pixel; a dark center among full-scale
    // neighbors checks that the average rounds down.
    task automatic test_min_interior();
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        for (int k = 0; k < 9; k++) begin
            send_pixel(k == 4 ? t_pix_in'('0) : t_pix_in'('1));
        end
    endtask

    // Two-wide frames pass everything through, with three words on the last
    // pixel; then a height cut below the current row forces a restart.
    task automatic test_narrow_and_restart();
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        repeat (8) send_pixel(random_pixel());
        drain_results();
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        send_frame();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int budget);
        int start;
        int w;
        int h;
        drain_results();
        src_idle_pct = src_pct;
        stall_pct    = snk_pct;
        start        = pixels_sent;
        while (pixels_sent - start < budget) begin
            if ($urandom_range(7) == 0) begin
                w = 0;
            end else if ($urandom_range(5) == 0) begin
                w = $urandom_range(10, 16);
            end else begin
                w = $urandom_range(1, 9);
            end
            h = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
            if (w > 9 && h > 3) h = 3;
            drain_results();
            // Bit 12 lies outside the width register and must be dropped.
            write_reg(CFG_FRAME_WIDTH, {1'($urandom_range(1)), 12'(w)});
            write_reg(CFG_FRAME_HEIGHT, 13'(h));
            send_frame();
        end
    endtask

    // The receiver holds off while pixels keep coming, so the input must stall.
    task automatic test_backpressure();
        drain_results();
        src_idle_pct = 0;
        stall_pct    = 0;
        write_reg(CFG_FRAME_WIDTH, 13'd5);
        write_reg(CFG_FRAME_HEIGHT, 13'd4);
        -> hold_go;
        send_frame();
        drain_results();
    endtask

    initial begin
        hold_on <= 1'b0;
        forever begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    // Output side: check each word taken, then pick the ready for the next edge.
    initial begin
        t_pix_out want;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word at row %0d col %0d",
                           o_out_data.out_row, o_out_data.out_col);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_data.out_red !== want.out_red) begin
                        $error("out_red: expected %0d, got %0d", want.out_red,
                               o_out_data.out_red);
                        fail_count++;
                    end
                    if (o_out_data.out_green !== want.out_green) begin
                        $error("out_green: expected %0d, got %0d", want.out_green,
                               o_out_data.out_green);
                        fail_count++;
                    end
                    if (o_out_data.out_blue !== want.out_blue) begin
                        $error("out_blue: expected %0d, got %0d", want.out_blue,
                               o_out_data.out_blue);
                        fail_count++;
                    end
                    if (o_out_data.out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d", want.out_row,
                               o_out_data.out_row);
                        fail_count++;
                    end
                    if (o_out_data.out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d", want.out_col,
                               o_out_data.out_col);
                        fail_count++;
                    end
                    if (o_out_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0d, got %0d", want.run_last,
                               o_out_data.run_last);
                        fail_count++;
                    end
                end
            end
            i_ready <= !hold_on && ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_words.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_FRAME_WIDTH;
        i_cfg_data <= '0;
        foreach (win[i]) win[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_zero_size();
        test_max_size();
        test_min_interior();
        test_narrow_and_restart();
        test_random_traffic(0, 0, 10);
        test_random_traffic(83, 0, 10);
        test_random_traffic(0, 83, 10);
        test_random_traffic(32, 32, 10);
        test_backpressure();
        drain_results();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
